@@ hw/rtl/lph_pkg.sv @@
// shared constants, types and helpers of the linear probe hash table
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;

    localparam int SLOTS    = 1024;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CAP_W    = IDX_W + 1;
    localparam int GUARD_W  = CAP_W + 1;
    localparam int KEY_W    = 16;
    localparam int VAL_W    = 32;
    localparam int HASH_W   = 32;
    localparam int REQ_W    = 2;
    localparam int OCC_W    = 10;
    localparam int CFG_W    = 11;

    // hash remainder unit: bits retired per cycle and cycle count
    localparam int DIV_STEP = 4;
    localparam int DIV_CYC  = HASH_W / DIV_STEP;
    localparam int DCNT_W   = $clog2(DIV_CYC);

    // request codes
    typedef logic [REQ_W-1:0] req_t;
    localparam req_t REQ_LOOKUP = 2'd0;
    localparam req_t REQ_INSERT = 2'd1;
    localparam req_t REQ_REMOVE = 2'd2;

    // configuration register indexes
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_TABLE_SIZE = 1'b0;
    localparam cfg_idx_t CFG_MAX_OCC    = 1'b1;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = CFG_W'(SLOTS);
    localparam logic [OCC_W-1:0] MAX_OCC_RESET    = OCC_W'(512);

    // classified request passed from front to back
    typedef struct packed {
        req_t             req;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] home;
        logic [VAL_W-1:0] val;
    } job_t;

    // one slot of the table memory
    typedef struct packed {
        logic [IDX_W-1:0] home;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // active table size, clamped to the legal range
    function automatic logic [CAP_W-1:0] cap_of(input logic [CFG_W-1:0] ts);
        logic [CAP_W-1:0] c;
        if (ts < CFG_W'(3)) begin
            c = CAP_W'(3);
        end else if (ts > CFG_W'(SLOTS)) begin
            c = CAP_W'(SLOTS);
        end else begin
            c = CAP_W'(ts);
        end
        return c;
    endfunction

    // next probe position, downward with wrap to the top slot
    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                   input logic [CAP_W-1:0] cap);
        logic [IDX_W-1:0] n;
        if (i == '0) begin
            n = IDX_W'(cap - CAP_W'(1));
        end else begin
            n = i - IDX_W'(1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/linear_probe_hash_table.sv @@
// top level of the linear probe hash table
//
// Key-value table with open addressing, linear probing downward from the
// home slot key_hash mod the clamped table size. Request beats enter on in_valid/in_ready
// (lookup, insert or replace, remove) and each gives exactly one result beat
// on out_valid/out_ready (found, old_value, status).
// The front end reduces the hash to a home slot, 4 hash bits a cycle, and
// hands the request to a two entry queue, so it takes the next beat while
// the back end still works. The back end walks the probe chain at one slot
// per cycle through one slot memory with a read and a write port: a request
// is taken in idle, probed and then answered, and a remove first runs the
// backward shift, clearing holes and scanning the slots below them.
// After reset the slot memory is cleared, one slot a cycle, all 1024 slots;
// no request beat is taken until then, configuration writes are.
// A stalled receiver holds the result register; the back end then waits with
// one more finished result, and the queue and front end fill before
// in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table
    import lph_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [KEY_W-1:0]  key_id,
    input  wire logic [HASH_W-1:0] key_hash,
    input  wire logic [VAL_W-1:0]  new_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic [VAL_W-1:0]       old_value,
    output logic                   status,
    input  wire logic              cfg_wr_en,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    logic [CFG_W-1:0] table_size_reg;
    logic [OCC_W-1:0] max_occ_reg;
    logic [CAP_W-1:0] cap;
    logic             init_done;
    logic             fq_valid, fq_ready;
    job_t             fq_job;
    logic             qb_valid, qb_ready;
    job_t             qb_job;

    assign cap = cap_of(table_size_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
            max_occ_reg    <= MAX_OCC_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TABLE_SIZE: table_size_reg <= cfg_wdata;
                CFG_MAX_OCC:    max_occ_reg    <= cfg_wdata[OCC_W-1:0];
                default:        table_size_reg <= table_size_reg;
            endcase
        end
    end

    lph_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (init_done),
        .cap       (cap),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .key_id    (key_id),
        .key_hash  (key_hash),
        .new_value (new_value),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    lph_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    lph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .max_occ   (max_occ_reg),
        .init_done (init_done),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .old_value (old_value),
        .status    (status)
    );

endmodule
`default_nettype wire

@@ hw/rtl/lph_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/lph_front.sv @@
// front end: accepts requests and reduces the hash to a home slot
`timescale 1ns / 1ps
`default_nettype none
module lph_front
    import lph_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              enable,
    input  wire logic [CAP_W-1:0]  cap,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [KEY_W-1:0]  key_id,
    input  wire logic [HASH_W-1:0] key_hash,
    input  wire logic [VAL_W-1:0]  new_value,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output job_t                   job
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [CAP_W-1:0]  rem_reg, rem_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    req_t              req_reg, req_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [CAP_W-1:0]  rem_step;
    logic              accept;

    assign in_ready  = enable && !busy_reg && !done_reg;
    assign accept    = in_valid && in_ready;
    assign job_valid = done_reg;
    assign job       = '{req: req_reg, key: key_reg, home: rem_reg[IDX_W-1:0], val: val_reg};

    // restoring remainder, several hash bits per cycle
    always_comb
    begin
        logic [CAP_W:0]   t;
        logic [CAP_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            t = {r, hash_reg[HASH_W-1-k]};
            if (t >= {1'b0, cap_reg})
            begin
                t = t - {1'b0, cap_reg};
            end
            r = t[CAP_W-1:0];
        end
        rem_step = r;
    end

    // sequencing of one request through the remainder unit
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        hash_next = hash_reg;
        cap_next  = cap_reg;
        req_next  = req_reg;
        key_next  = key_reg;
        val_next  = val_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            hash_next = key_hash;
            cap_next  = cap;
            req_next  = req_t'(req_type);
            key_next  = key_id;
            val_next  = new_value;
        end
        else if (busy_reg)
        begin
            rem_next  = rem_step;
            hash_next = hash_reg << DIV_STEP;
            cnt_next  = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(DIV_CYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && job_ready)
        begin
            done_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        hash_reg <= hash_next;
        cap_reg  <= cap_next;
        req_reg  <= req_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/lph_queue.sv @@
// two entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module lph_queue
    import lph_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  job_t      push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_data
);

    job_t       entry_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lph_back.sv @@
// back end: probe, insert, replace and backward shift remove on slot memory
`timescale 1ns / 1ps
`default_nettype none
module lph_back
    import lph_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CAP_W-1:0] cap,
    input  wire logic [OCC_W-1:0] max_occ,
    output logic                  init_done,
    input  wire logic             job_valid,
    output logic                  job_ready,
    input  job_t                  job,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  found,
    output logic [VAL_W-1:0]      old_value,
    output logic                  status
);

    typedef enum logic [5:0] {
        S_INIT    = 6'b000001,
        S_IDLE    = 6'b000010,
        S_PROBE   = 6'b000100,
        S_SH_CLR  = 6'b001000,
        S_SH_SCAN = 6'b010000,
        S_RESP    = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   clr_reg, clr_next;
    logic [CAP_W-1:0]   count_reg, count_next;
    logic               ovalid_reg, ovalid_next;
    logic               ofound_reg, ofound_next;
    logic [VAL_W-1:0]   oold_reg, oold_next;
    logic               ostat_reg, ostat_next;
    logic               pfound_reg, pfound_next;
    logic [VAL_W-1:0]   pold_reg, pold_next;
    logic               pstat_reg, pstat_next;
    req_t               req_reg, req_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]   home_reg, home_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [CAP_W-1:0]   n_reg, n_next;
    logic [GUARD_W-1:0] guard_reg, guard_next;
    logic [GUARD_W-1:0] limit_reg, limit_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    slot_t              ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    slot_t              rd;
    logic [SLOT_W-1:0]  rd_bits;

    assign rd        = slot_t'(rd_bits);
    assign init_done = (state_reg != S_INIT);
    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign found     = ofound_reg;
    assign old_value = oold_reg;
    assign status    = ostat_reg;

    lph_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_bits)
    );

    // sequencer
    always_comb
    begin
        logic             empty;
        logic             match;
        logic             room;
        logic [IDX_W-1:0] nx;
        logic [IDX_W-1:0] r;
        logic             stay;
        state_next  = state_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg;
        ofound_next = ofound_reg;
        oold_next   = oold_reg;
        ostat_next  = ostat_reg;
        pfound_next = pfound_reg;
        pold_next   = pold_reg;
        pstat_next  = pstat_reg;
        req_next    = req_reg;
        key_next    = key_reg;
        home_next   = home_reg;
        val_next    = val_reg;
        cap_next    = cap_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        guard_next  = guard_reg;
        limit_next  = limit_reg;
        ram_we      = 1'b0;
        ram_waddr   = i_reg;
        ram_wdata   = '0;
        ram_raddr   = i_reg;
        empty       = (rd.val == '0);
        match       = !empty && (rd.key == key_reg);
        room        = ({1'b0, count_reg} + (CAP_W + 1)'(1) < (CAP_W + 1)'(max_occ))
                      && ({1'b0, count_reg} + (CAP_W + 1)'(2) < {1'b0, cap_reg});
        nx          = step_down(i_reg, cap_reg);
        r           = rd.home;
        stay        = (i_reg <= r && r < j_reg) || (r < j_reg && j_reg < i_reg)
                      || (j_reg < i_reg && i_reg <= r);

        // output register drains independently
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[IDX_W-1:0];
                clr_next  = clr_reg + CAP_W'(1);
                if (clr_reg == CAP_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = job.home;
                if (job_valid)
                begin
                    req_next   = job.req;
                    key_next   = job.key;
                    home_next  = job.home;
                    val_next   = job.val;
                    cap_next   = cap;
                    limit_next = {cap, 1'b0} + GUARD_W'(2);
                    i_next     = job.home;
                    n_next     = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                pfound_next = match;
                pold_next   = match ? rd.val : '0;
                pstat_next  = 1'b0;
                if (empty || match)
                begin
                    state_next = S_RESP;
                    if (req_reg == REQ_INSERT && val_reg != '0)
                    begin
                        if (match)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = '{home: rd.home, key: rd.key, val: val_reg};
                        end
                        else if (room)
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = '{home: home_reg, key: key_reg, val: val_reg};
                            count_next = count_reg + CAP_W'(1);
                        end
                        else
                        begin
                            pstat_next = 1'b1;
                        end
                    end
                    else if (req_reg == REQ_REMOVE && match)
                    begin
                        j_next     = i_reg;
                        guard_next = '0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CAP_W'(1);
                        end
                        state_next = S_SH_CLR;
                    end
                end
                else if (n_reg + CAP_W'(1) == cap_reg)
                begin
                    // probe exhausted without key or empty slot
                    pstat_next = (req_reg == REQ_INSERT && val_reg != '0);
                    state_next = S_RESP;
                end
                else
                begin
                    n_next    = n_reg + CAP_W'(1);
                    i_next    = nx;
                    ram_raddr = nx;
                end
            end
            S_SH_CLR:
            begin
                // free the hole and look at the slot below it
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                i_next     = step_down(j_reg, cap_reg);
                ram_raddr  = step_down(j_reg, cap_reg);
                guard_next = guard_reg + GUARD_W'(1);
                state_next = S_SH_SCAN;
            end
            S_SH_SCAN:
            begin
                if (empty)
                begin
                    state_next = S_RESP;
                end
                else if (guard_reg >= limit_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = j_reg;
                    ram_wdata  = rd;
                    state_next = S_RESP;
                end
                else if (!stay)
                begin
                    // entry moves back into the hole, its slot becomes the new hole
                    ram_we     = 1'b1;
                    ram_waddr  = j_reg;
                    ram_wdata  = rd;
                    j_next     = i_reg;
                    state_next = S_SH_CLR;
                end
                else
                begin
                    i_next     = nx;
                    ram_raddr  = nx;
                    guard_next = guard_reg + GUARD_W'(1);
                end
            end
            S_RESP:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    ofound_next = pfound_reg;
                    oold_next   = pold_reg;
                    ostat_next  = pstat_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            clr_reg    <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        ofound_reg <= ofound_next;
        oold_reg   <= oold_next;
        ostat_reg  <= ostat_next;
        pfound_reg <= pfound_next;
        pold_reg   <= pold_next;
        pstat_reg  <= pstat_next;
        req_reg    <= req_next;
        key_reg    <= key_next;
        home_reg   <= home_next;
        val_reg    <= val_next;
        cap_reg    <= cap_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        guard_reg  <= guard_next;
        limit_reg  <= limit_next;
    end

endmodule
`default_nettype wire
